### rtl/assert_macros.svh
// Assertion helpers used by the checked top-level controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is high.
`define AIJC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also runs through reset.
`define AIJC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/aijc_pkg.sv
package aijc_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int FRAC_BITS   = 20;
  localparam int JOINT_COUNT = 7;
  localparam int JOINT_W     = 3;
  localparam int JIDX_W      = $clog2(JOINT_COUNT);
  localparam int REG_COUNT   = 7;
  localparam int REG_W       = 31;
  localparam int CFG_IDX_W   = 3;
  localparam int SUM_W       = 31;
  localparam int PROD_W      = 2 * DATA_WIDTH;
  localparam int MUL_STEPS   = DATA_WIDTH;
  localparam int MUL_CNT_W   = $clog2(MUL_STEPS);
  localparam int LOAD_COUNT  = 18;
  localparam int LOAD_W      = $clog2(LOAD_COUNT);
  localparam int PROG_LEN    = 46;
  localparam int PC_W        = $clog2(PROG_LEN);

  typedef logic signed [DATA_WIDTH-1:0] value_t;

  localparam value_t VALUE_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam value_t VALUE_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    R_PREC_POS, R_PREC_VEL, R_PREC_BEL, R_PREC_RATE, R_BEL_GAIN, R_ACT_GAIN, R_STEP
  } reg_idx_t;

  localparam logic [REG_W-1:0] REG_RESET [REG_COUNT] = '{
    31'd209715, 31'd1048576, 31'd209715, 31'd104858, 31'd12236882, 31'd419430400, 31'd1049
  };

  // Scratch slots; the first LOAD_COUNT are filled at the start of each item.
  typedef enum logic [4:0] {
    S_ZERO, S_Q, S_QD, S_GOAL, S_PQ, S_PDQ, S_PMU, S_PMUR, S_KMU, S_KA, S_H,
    S_MU, S_MUP, S_MUPP, S_TQ, S_FES, S_PES, S_VES,
    S_EQ, S_EDQ, S_EMU, S_EMUR,
    S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_T6, S_T7, S_T8
  } slot_t;

  typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL} op_t;

  typedef struct packed {
    op_t   op;
    slot_t dst;
    slot_t a;
    slot_t b;
  } instr_t;

  localparam instr_t PROGRAM [PROG_LEN] = '{
    '{OP_SUB, S_EQ,   S_Q,    S_MU},
    '{OP_SUB, S_EDQ,  S_QD,   S_MUP},
    '{OP_ADD, S_T0,   S_MUP,  S_MU},
    '{OP_SUB, S_EMU,  S_T0,   S_GOAL},
    '{OP_ADD, S_EMUR, S_MUPP, S_MUP},
    '{OP_MUL, S_T0,   S_EQ,   S_EQ},
    '{OP_MUL, S_T1,   S_T0,   S_PQ},
    '{OP_MUL, S_T0,   S_EDQ,  S_EDQ},
    '{OP_MUL, S_T2,   S_T0,   S_PDQ},
    '{OP_MUL, S_T0,   S_EMU,  S_EMU},
    '{OP_MUL, S_T3,   S_T0,   S_PMU},
    '{OP_MUL, S_T0,   S_EMUR, S_EMUR},
    '{OP_MUL, S_T4,   S_T0,   S_PMUR},
    '{OP_ADD, S_T5,   S_T1,   S_T2},
    '{OP_ADD, S_T6,   S_T3,   S_T4},
    '{OP_ADD, S_T5,   S_T5,   S_T6},
    '{OP_ADD, S_FES,  S_FES,  S_T5},
    '{OP_ADD, S_PES,  S_PES,  S_T1},
    '{OP_ADD, S_VES,  S_VES,  S_T2},
    '{OP_MUL, S_T1,   S_PMU,  S_EMU},
    '{OP_MUL, S_T0,   S_PQ,   S_EQ},
    '{OP_SUB, S_T2,   S_T1,   S_T0},
    '{OP_MUL, S_T3,   S_KMU,  S_T2},
    '{OP_SUB, S_T4,   S_MUP,  S_T3},
    '{OP_MUL, S_T0,   S_PDQ,  S_EDQ},
    '{OP_SUB, S_T2,   S_T1,   S_T0},
    '{OP_MUL, S_T5,   S_PMUR, S_EMUR},
    '{OP_ADD, S_T2,   S_T2,   S_T5},
    '{OP_MUL, S_T3,   S_KMU,  S_T2},
    '{OP_SUB, S_T6,   S_MUPP, S_T3},
    '{OP_MUL, S_T3,   S_KMU,  S_T5},
    '{OP_SUB, S_T7,   S_ZERO, S_T3},
    '{OP_MUL, S_T3,   S_H,    S_T4},
    '{OP_ADD, S_MU,   S_MU,   S_T3},
    '{OP_MUL, S_T3,   S_H,    S_T6},
    '{OP_ADD, S_MUP,  S_MUP,  S_T3},
    '{OP_MUL, S_T3,   S_H,    S_T7},
    '{OP_ADD, S_MUPP, S_MUPP, S_T3},
    '{OP_MUL, S_T8,   S_H,    S_KA},
    '{OP_SUB, S_T0,   S_QD,   S_MUP},
    '{OP_MUL, S_T0,   S_PDQ,  S_T0},
    '{OP_SUB, S_T1,   S_Q,    S_MU},
    '{OP_MUL, S_T1,   S_PQ,   S_T1},
    '{OP_ADD, S_T0,   S_T0,   S_T1},
    '{OP_MUL, S_T0,   S_T8,   S_T0},
    '{OP_SUB, S_TQ,   S_TQ,   S_T0}
  };

  typedef struct packed {
    logic [JOINT_W-1:0]     joint_index;
    logic signed [31:0]     joint_position;
    logic signed [31:0]     joint_velocity;
    logic signed [31:0]     target_position;
    logic                   last_joint;
  } in_word_t;

  typedef struct packed {
    logic [JOINT_W-1:0]     joint_out;
    logic signed [31:0]     torque;
    logic signed [31:0]     belief_pos_out;
    logic signed [31:0]     belief_vel_out;
    logic signed [31:0]     belief_acc_out;
    logic [SUM_W-1:0]       free_energy;
    logic [SUM_W-1:0]       position_error;
    logic [SUM_W-1:0]       velocity_error;
    logic                   tick_done;
  } out_word_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [REG_W-1:0]     value;
  } cfg_word_t;

  typedef struct packed {
    value_t q, qd, goal;
    value_t pq, pdq, pmu, pmur, kmu, ka, h;
    value_t mu, mup, mupp, tq;
    value_t fes, pes, ves;
  } seed_t;

  typedef struct packed {
    value_t mu, mup, mupp, tq;
    value_t fes, pes, ves;
  } result_t;

  typedef enum logic [1:0] {T_IDLE, T_START, T_RUN, T_COMMIT} top_state_t;
  typedef enum logic [2:0] {E_IDLE, E_LOAD, E_READ, E_EXEC, E_MUL, E_DONE} eng_state_t;
  typedef enum logic [1:0] {M_IDLE, M_RUN, M_FINAL} mul_state_t;

  function automatic value_t sat_addsub(value_t a, value_t b, logic sub);
    logic signed [DATA_WIDTH:0] s;
    s = sub ? ({a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b})
            : ({a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b});
    if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
      return s[DATA_WIDTH] ? VALUE_MIN : VALUE_MAX;
    end
    return s[DATA_WIDTH-1:0];
  endfunction

endpackage

### rtl/aijc_if.sv
interface aijc_in_if;
  logic               valid;
  logic               ready;
  aijc_pkg::in_word_t data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

interface aijc_out_if;
  logic                valid;
  logic                ready;
  aijc_pkg::out_word_t data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

interface aijc_cfg_if;
  logic                valid;
  logic                ready;
  aijc_pkg::cfg_word_t data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

### rtl/aijc_serial_mul.sv
// Q12.20 product, one multiplier bit per cycle, round half away, saturate.
module aijc_serial_mul (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  aijc_pkg::value_t a,
  input  aijc_pkg::value_t b,
  output logic             done,
  output aijc_pkg::value_t product
);

  localparam int DW = aijc_pkg::DATA_WIDTH;

  aijc_pkg::mul_state_t state, state_next;
  logic [aijc_pkg::MUL_CNT_W-1:0] cnt;
  logic [DW-1:0] ua, hi, lo;
  logic          neg;

  logic [DW:0]                   sum;
  logic [aijc_pkg::PROD_W-1:0]   rnd;
  logic [aijc_pkg::PROD_W-aijc_pkg::FRAC_BITS-1:0] mag;
  logic [DW-1:0]                 lim, mag_sat;

  always_comb begin
    sum     = {1'b0, hi} + (lo[0] ? {1'b0, ua} : '0);
    rnd     = {hi, lo} + aijc_pkg::ROUND_HALF;
    mag     = rnd[aijc_pkg::PROD_W-1:aijc_pkg::FRAC_BITS];
    lim     = neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    mag_sat = (mag > {{(aijc_pkg::PROD_W-aijc_pkg::FRAC_BITS-DW){1'b0}}, lim})
              ? lim : mag[DW-1:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      aijc_pkg::M_IDLE:  if (start) state_next = aijc_pkg::M_RUN;
      aijc_pkg::M_RUN:   if (cnt == aijc_pkg::MUL_CNT_W'(aijc_pkg::MUL_STEPS - 1))
                           state_next = aijc_pkg::M_FINAL;
      aijc_pkg::M_FINAL: state_next = aijc_pkg::M_IDLE;
      default:           state_next = aijc_pkg::M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aijc_pkg::M_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == aijc_pkg::M_FINAL);
    end
  end

  always_ff @(posedge clk) begin
    if (state == aijc_pkg::M_IDLE && start) begin
      ua  <= a[DW-1] ? DW'(0) - a : a;
      lo  <= b[DW-1] ? DW'(0) - b : b;
      hi  <= '0;
      neg <= a[DW-1] ^ b[DW-1];
      cnt <= '0;
    end else if (state == aijc_pkg::M_RUN) begin
      // add, then shift the partial product one bit right
      hi  <= sum[DW:1];
      lo  <= {sum[0], lo[DW-1:1]};
      cnt <= cnt + 1'b1;
    end else if (state == aijc_pkg::M_FINAL) begin
      product <= neg ? DW'(0) - mag_sat : mag_sat;
    end
  end

endmodule

### rtl/aijc_engine.sv
// Microprogram sequencer over a scratch memory with one serial multiplier.
module aijc_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  aijc_pkg::seed_t   seed,
  output logic              done,
  output aijc_pkg::result_t res
);

  aijc_pkg::eng_state_t state, state_next;
  logic [aijc_pkg::PC_W-1:0]   pc;
  logic [aijc_pkg::LOAD_W-1:0] load_cnt;

  aijc_pkg::value_t scratch [32];
  aijc_pkg::value_t rd_a, rd_b;

  aijc_pkg::instr_t instr;
  aijc_pkg::value_t alu, load_val, wr_data, mul_res;
  aijc_pkg::slot_t  wr_addr;
  logic             wr_en, mul_start, mul_done, advance;

  assign instr = aijc_pkg::PROGRAM[pc];
  assign alu   = aijc_pkg::sat_addsub(rd_a, rd_b, instr.op == aijc_pkg::OP_SUB);

  always_comb begin
    case (aijc_pkg::slot_t'(load_cnt))
      aijc_pkg::S_Q:    load_val = seed.q;
      aijc_pkg::S_QD:   load_val = seed.qd;
      aijc_pkg::S_GOAL: load_val = seed.goal;
      aijc_pkg::S_PQ:   load_val = seed.pq;
      aijc_pkg::S_PDQ:  load_val = seed.pdq;
      aijc_pkg::S_PMU:  load_val = seed.pmu;
      aijc_pkg::S_PMUR: load_val = seed.pmur;
      aijc_pkg::S_KMU:  load_val = seed.kmu;
      aijc_pkg::S_KA:   load_val = seed.ka;
      aijc_pkg::S_H:    load_val = seed.h;
      aijc_pkg::S_MU:   load_val = seed.mu;
      aijc_pkg::S_MUP:  load_val = seed.mup;
      aijc_pkg::S_MUPP: load_val = seed.mupp;
      aijc_pkg::S_TQ:   load_val = seed.tq;
      aijc_pkg::S_FES:  load_val = seed.fes;
      aijc_pkg::S_PES:  load_val = seed.pes;
      aijc_pkg::S_VES:  load_val = seed.ves;
      default:          load_val = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    wr_en      = 1'b0;
    wr_addr    = instr.dst;
    wr_data    = alu;
    mul_start  = 1'b0;
    advance    = 1'b0;
    done       = 1'b0;
    unique case (state)
      aijc_pkg::E_IDLE: if (start) state_next = aijc_pkg::E_LOAD;
      aijc_pkg::E_LOAD: begin
        wr_en   = 1'b1;
        wr_addr = aijc_pkg::slot_t'(load_cnt);
        wr_data = load_val;
        if (load_cnt == aijc_pkg::LOAD_W'(aijc_pkg::LOAD_COUNT - 1))
          state_next = aijc_pkg::E_READ;
      end
      aijc_pkg::E_READ: state_next = aijc_pkg::E_EXEC;
      aijc_pkg::E_EXEC: begin
        if (instr.op == aijc_pkg::OP_MUL) begin
          mul_start  = 1'b1;
          state_next = aijc_pkg::E_MUL;
        end else begin
          wr_en   = 1'b1;
          advance = 1'b1;
        end
      end
      aijc_pkg::E_MUL: begin
        if (mul_done) begin
          wr_en   = 1'b1;
          wr_data = mul_res;
          advance = 1'b1;
        end
      end
      aijc_pkg::E_DONE: begin
        done       = 1'b1;
        state_next = aijc_pkg::E_IDLE;
      end
      default: state_next = aijc_pkg::E_IDLE;
    endcase
    if (advance) begin
      state_next = (pc == aijc_pkg::PC_W'(aijc_pkg::PROG_LEN - 1))
                   ? aijc_pkg::E_DONE : aijc_pkg::E_READ;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= aijc_pkg::E_IDLE;
      pc       <= '0;
      load_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == aijc_pkg::E_IDLE) begin
        pc       <= '0;
        load_cnt <= '0;
      end else begin
        if (state == aijc_pkg::E_LOAD) load_cnt <= load_cnt + 1'b1;
        if (advance) pc <= pc + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) scratch[wr_addr] <= wr_data;
    rd_a <= scratch[instr.a];
    rd_b <= scratch[instr.b];
  end

  // shadow the slots that go back to joint state
  always_ff @(posedge clk) begin
    if (wr_en) begin
      case (wr_addr)
        aijc_pkg::S_MU:   res.mu   <= wr_data;
        aijc_pkg::S_MUP:  res.mup  <= wr_data;
        aijc_pkg::S_MUPP: res.mupp <= wr_data;
        aijc_pkg::S_TQ:   res.tq   <= wr_data;
        aijc_pkg::S_FES:  res.fes  <= wr_data;
        aijc_pkg::S_PES:  res.pes  <= wr_data;
        aijc_pkg::S_VES:  res.ves  <= wr_data;
        default: ;
      endcase
    end
  end

  aijc_serial_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (rd_a),
    .b       (rd_b),
    .done    (mul_done),
    .product (mul_res)
  );

endmodule

### rtl/active_inference_joint_controller_top.sv
// Active inference joint controller. Each sample word carries one joint's
// measured position, velocity and goal (signed Q12.20); the block answers with
// one result word holding the joint's new torque command, its updated position,
// rate and acceleration beliefs, and the running free energy and weighted
// position and velocity error sums of the current tick. The first sample of a
// joint seeds its position and rate beliefs from the measurement. Sums restart
// after a word with last_joint set, which is echoed as tick_done. A sample
// whose joint_index is 7 is taken and dropped with no result. One sample is
// worked at a time: each result needs the 22 products of the update, each run
// through the one-bit-per-cycle multiplier, plus a load of the 18 scratch
// slots and 24 adds or subtracts. A new sample is taken while the previous
// result still waits on the output. Configuration writes are always ready and
// must be made while idle.
`include "assert_macros.svh"

module active_inference_joint_controller_top (
  input logic       clk,
  input logic       rst,
  aijc_in_if.sink   sample,
  aijc_out_if.source result,
  aijc_cfg_if.sink  cfg
);

  aijc_pkg::top_state_t state, state_next;

  // configuration registers
  logic [aijc_pkg::REG_W-1:0] cfg_regs [aijc_pkg::REG_COUNT];

  // per-joint state
  aijc_pkg::value_t bel_pos [aijc_pkg::JOINT_COUNT];
  aijc_pkg::value_t bel_vel [aijc_pkg::JOINT_COUNT];
  aijc_pkg::value_t bel_acc [aijc_pkg::JOINT_COUNT];
  aijc_pkg::value_t trq     [aijc_pkg::JOINT_COUNT];
  logic             seen    [aijc_pkg::JOINT_COUNT];

  // running sums of the tick
  logic [aijc_pkg::SUM_W-1:0] fe_sum, pe_sum, ve_sum;

  aijc_pkg::in_word_t  cur;
  aijc_pkg::out_word_t out_word;
  logic                out_valid;

  aijc_pkg::seed_t   seed;
  aijc_pkg::result_t res;
  logic              eng_start, eng_done, commit, accept, joint_ok;
  logic [aijc_pkg::JIDX_W-1:0] j;

  assign j        = cur.joint_index[aijc_pkg::JIDX_W-1:0];
  assign joint_ok = sample.data.joint_index < aijc_pkg::JOINT_W'(aijc_pkg::JOINT_COUNT);
  assign accept   = sample.valid && sample.ready;

  assign cfg.ready    = 1'b1;
  assign result.valid = out_valid;
  assign result.data  = out_word;

  // seed the scratch memory; an unseen joint takes its measurement
  always_comb begin
    seed.q    = cur.joint_position;
    seed.qd   = cur.joint_velocity;
    seed.goal = cur.target_position;
    seed.pq   = {1'b0, cfg_regs[aijc_pkg::R_PREC_POS]};
    seed.pdq  = {1'b0, cfg_regs[aijc_pkg::R_PREC_VEL]};
    seed.pmu  = {1'b0, cfg_regs[aijc_pkg::R_PREC_BEL]};
    seed.pmur = {1'b0, cfg_regs[aijc_pkg::R_PREC_RATE]};
    seed.kmu  = {1'b0, cfg_regs[aijc_pkg::R_BEL_GAIN]};
    seed.ka   = {1'b0, cfg_regs[aijc_pkg::R_ACT_GAIN]};
    seed.h    = {1'b0, cfg_regs[aijc_pkg::R_STEP]};
    seed.mu   = seen[j] ? bel_pos[j] : cur.joint_position;
    seed.mup  = seen[j] ? bel_vel[j] : cur.joint_velocity;
    seed.mupp = bel_acc[j];
    seed.tq   = trq[j];
    seed.fes  = {1'b0, fe_sum};
    seed.pes  = {1'b0, pe_sum};
    seed.ves  = {1'b0, ve_sum};
  end

  always_comb begin
    state_next   = state;
    sample.ready = 1'b0;
    eng_start    = 1'b0;
    commit       = 1'b0;
    unique case (state)
      aijc_pkg::T_IDLE: begin
        sample.ready = 1'b1;
        // drop a word for a joint that does not exist
        if (sample.valid && joint_ok) state_next = aijc_pkg::T_START;
      end
      aijc_pkg::T_START: begin
        eng_start  = 1'b1;
        state_next = aijc_pkg::T_RUN;
      end
      aijc_pkg::T_RUN: if (eng_done) state_next = aijc_pkg::T_COMMIT;
      aijc_pkg::T_COMMIT: begin
        // hold until the output register is free
        if (!out_valid || result.ready) begin
          commit     = 1'b1;
          state_next = aijc_pkg::T_IDLE;
        end
      end
      default: state_next = aijc_pkg::T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= aijc_pkg::T_IDLE;
      out_valid <= 1'b0;
      fe_sum    <= '0;
      pe_sum    <= '0;
      ve_sum    <= '0;
      for (int i = 0; i < aijc_pkg::REG_COUNT; i++) cfg_regs[i] <= aijc_pkg::REG_RESET[i];
      for (int i = 0; i < aijc_pkg::JOINT_COUNT; i++) begin
        bel_pos[i] <= '0;
        bel_vel[i] <= '0;
        bel_acc[i] <= '0;
        trq[i]     <= '0;
        seen[i]    <= 1'b0;
      end
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.data.index < aijc_pkg::CFG_IDX_W'(aijc_pkg::REG_COUNT))
        cfg_regs[cfg.data.index] <= cfg.data.value;
      if (commit) begin
        bel_pos[j] <= res.mu;
        bel_vel[j] <= res.mup;
        bel_acc[j] <= res.mupp;
        trq[j]     <= res.tq;
        seen[j]    <= 1'b1;
        // restart the sums after the last joint of the tick
        fe_sum     <= cur.last_joint ? '0 : res.fes[aijc_pkg::SUM_W-1:0];
        pe_sum     <= cur.last_joint ? '0 : res.pes[aijc_pkg::SUM_W-1:0];
        ve_sum     <= cur.last_joint ? '0 : res.ves[aijc_pkg::SUM_W-1:0];
        out_valid  <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == aijc_pkg::T_IDLE && accept) cur <= sample.data;
    if (commit) begin
      out_word.joint_out      <= cur.joint_index;
      out_word.torque         <= res.tq;
      out_word.belief_pos_out <= res.mu;
      out_word.belief_vel_out <= res.mup;
      out_word.belief_acc_out <= res.mupp;
      out_word.free_energy    <= res.fes[aijc_pkg::SUM_W-1:0];
      out_word.position_error <= res.pes[aijc_pkg::SUM_W-1:0];
      out_word.velocity_error <= res.ves[aijc_pkg::SUM_W-1:0];
      out_word.tick_done      <= cur.last_joint;
    end
  end

  aijc_engine u_engine (
    .clk   (clk),
    .rst   (rst),
    .start (eng_start),
    .seed  (seed),
    .done  (eng_done),
    .res   (res)
  );

  `AIJC_ASSERT(a_done_in_run, clk, rst, eng_done |-> state == aijc_pkg::T_RUN, "engine done outside run")
  `AIJC_ASSERT(a_commit_hold, clk, rst, (state == aijc_pkg::T_COMMIT && out_valid && !result.ready) |=> state == aijc_pkg::T_COMMIT, "commit over a waiting result")
  `AIJC_ASSERT(a_drop_bad_joint, clk, rst, (accept && !joint_ok) |=> state == aijc_pkg::T_IDLE, "out of range joint started")
  `AIJC_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> (!out_valid && state == aijc_pkg::T_IDLE), "reset left work pending")

endmodule
